// ===== src/ktsamp_pkg.sv =====
// Shared types and constants for the keyframe track sampler.
// No dependencies; used by every module in src except ktsamp_chk.
package ktsamp_pkg;

    localparam int MAX_KEYS  = 64;
    localparam int KEY_AW    = $clog2(MAX_KEYS);
    localparam int KEY_CW    = KEY_AW + 1;
    localparam int FRAC_BITS = 16;
    localparam int DIV_W     = 48;
    localparam int DIV_CW    = $clog2(DIV_W);

    // 0.0001 frame rounded to the nearest LSB
    localparam logic [31:0] MIN_GAP = 32'(((1 << FRAC_BITS) + 5000) / 10000);
    localparam logic [FRAC_BITS:0] ONE_Q = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [1:0] WRAP_CLAMP    = 2'd0;
    localparam logic [1:0] WRAP_REPEAT   = 2'd1;
    localparam logic [1:0] WRAP_PINGPONG = 2'd2;

    localparam logic [2:0] REG_KEY_COUNT = 3'd0;
    localparam logic [2:0] REG_DURATION  = 3'd1;
    localparam logic [2:0] REG_FPS       = 3'd2;
    localparam logic [2:0] REG_WRAP      = 3'd3;
    localparam logic [2:0] REG_REST      = 3'd4;

    typedef struct packed {
        logic [31:0] frame_time;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } key_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [31:0]      divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [31:0]      rem;
    } div_rsp_t;

endpackage

// ===== src/ktsamp_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ktsamp_pkg.
module ktsamp_div (
    input  logic                clk,
    input  logic                rst_n,
    input  ktsamp_pkg::div_req_t req,
    output ktsamp_pkg::div_rsp_t rsp
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [ktsamp_pkg::DIV_CW-1:0] cnt_reg, cnt_next;
    logic [ktsamp_pkg::DIV_W-1:0]  quo_reg, quo_next;
    logic [31:0]                   rem_reg, rem_next;
    logic [31:0]                   dvs_reg, dvs_next;
    logic [32:0]                   shifted;
    logic                          ge;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[ktsamp_pkg::DIV_W-1]};
        ge        = shifted >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 32'(shifted - {1'b0, dvs_reg}) : shifted[31:0];
            quo_next = {quo_reg[ktsamp_pkg::DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ktsamp_pkg::DIV_CW'(ktsamp_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== src/ktsamp_store.sv =====
// Keyframe memory: one write port, one read port with registered data.
// Depends on ktsamp_pkg.
module ktsamp_store (
    input  logic                          clk,
    input  logic                          we,
    input  logic [ktsamp_pkg::KEY_AW-1:0] waddr,
    input  ktsamp_pkg::key_t              wdata,
    input  logic [ktsamp_pkg::KEY_AW-1:0] raddr,
    output ktsamp_pkg::key_t              rdata
);

    ktsamp_pkg::key_t mem [ktsamp_pkg::MAX_KEYS];
    ktsamp_pkg::key_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/keyframe_track_sampler_top.sv =====
// Keyframe track sampler. A write word (op 0) stores one keyframe and leaves the
// block ready at once. A sample word (op 1) holds the input stalled while a small sequencer
// works: the seconds-to-frames multiply, the wrap step, the bit-serial divider (48 quotient
// bits) for repeat or ping-pong wrap (none for clamp), the scan start (S_SINIT, S_S0), the
// candidate pairs tested in turn through the single read port of the keyframe memory (up to
// key_count - 1, at most 63), a second division for the interpolation factor, reading the
// pair, the three lerps sharing one multiplier, and the hand-over of the result. With fewer
// than two keys the scan is skipped; with no pair found the factor division and lerps are
// skipped. A disabled track (duration 0) goes straight to the hand-over. A finished result
// waits there while the output register is full and stalled. The result sits in an output
// register, so the next word is taken while a finished result still waits under out_stall.
// Depends on ktsamp_pkg, ktsamp_div, ktsamp_store.
module keyframe_track_sampler_top (
    input  logic               clk,
    input  logic               rst_n,
    // APB-style config
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic [5:0]         key_slot,
    input  logic [31:0]        key_frame_time,
    input  logic signed [31:0] key_x,
    input  logic signed [31:0] key_y,
    input  logic signed [31:0] key_z,
    input  logic signed [31:0] sample_seconds,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic               pair_found,
    output logic               track_active
);

    localparam int FB = ktsamp_pkg::FRAC_BITS;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;   // frames = seconds * fps / 256
    localparam logic [3:0] S_WRAP  = 4'd2;   // clamp, or launch wrap division
    localparam logic [3:0] S_WDIV  = 4'd3;   // wait wrap division
    localparam logic [3:0] S_SINIT = 4'd4;   // read slot 0
    localparam logic [3:0] S_S0    = 4'd5;   // latch slot 0, read slot 1
    localparam logic [3:0] S_SCMP  = 4'd6;   // bracket test, one slot per cycle
    localparam logic [3:0] S_FDIV  = 4'd7;   // factor division, low key read
    localparam logic [3:0] S_RA    = 4'd8;   // latch low key
    localparam logic [3:0] S_RB    = 4'd9;   // latch high key
    localparam logic [3:0] S_LMUL  = 4'd10;  // lerp multiply
    localparam logic [3:0] S_LADD  = 4'd11;  // lerp add and saturate
    localparam logic [3:0] S_DONE  = 4'd12;  // hand result to output register

    // configuration
    logic [6:0]  key_count_reg;
    logic [31:0] duration_reg;
    logic [15:0] fps_reg;
    logic [1:0]  wrap_mode_reg;
    logic        rest_kind_reg;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= '0;
            duration_reg  <= '0;
            fps_reg       <= 16'd7680;
            wrap_mode_reg <= ktsamp_pkg::WRAP_REPEAT;
            rest_kind_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (paddr[4:2])
                ktsamp_pkg::REG_KEY_COUNT: key_count_reg <= pwdata[6:0];
                ktsamp_pkg::REG_DURATION:  duration_reg  <= pwdata;
                ktsamp_pkg::REG_FPS:       fps_reg       <= pwdata[15:0];
                ktsamp_pkg::REG_WRAP:      wrap_mode_reg <= pwdata[1:0];
                ktsamp_pkg::REG_REST:      rest_kind_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            ktsamp_pkg::REG_KEY_COUNT: prdata = {25'd0, key_count_reg};
            ktsamp_pkg::REG_DURATION:  prdata = duration_reg;
            ktsamp_pkg::REG_FPS:       prdata = {16'd0, fps_reg};
            ktsamp_pkg::REG_WRAP:      prdata = {30'd0, wrap_mode_reg};
            ktsamp_pkg::REG_REST:      prdata = {31'd0, rest_kind_reg};
            default:                   prdata = '0;
        endcase
    end

    // working registers
    logic [3:0]                        state_reg, state_next;
    logic signed [31:0]                sec_reg, sec_next;
    logic signed [40:0]                frames_reg, frames_next;
    logic [31:0]                       t_reg, t_next;
    logic [31:0]                       prev_reg, prev_next;
    logic [ktsamp_pkg::KEY_CW-1:0]     idx_reg, idx_next;
    logic [FB:0]                       fac_reg, fac_next;
    logic signed [31:0]                a_reg [3], a_next [3];
    logic signed [31:0]                b_reg [3], b_next [3];
    logic signed [31:0]                res_reg [3], res_next [3];
    logic signed [50:0]                prod_reg, prod_next;
    logic [1:0]                        comp_reg, comp_next;
    logic                              found_reg, found_next;
    logic                              active_reg, active_next;

    // output register
    logic                              ovalid_reg, ovalid_next;
    logic signed [31:0]                ox_reg, ox_next;
    logic signed [31:0]                oy_reg, oy_next;
    logic signed [31:0]                oz_reg, oz_next;
    logic                              ofound_reg, ofound_next;
    logic                              oactive_reg, oactive_next;

    // memory and divider
    logic                              mem_we;
    ktsamp_pkg::key_t                  mem_wdata;
    logic [ktsamp_pkg::KEY_AW-1:0]     mem_raddr;
    ktsamp_pkg::key_t                  mem_rdata;
    ktsamp_pkg::div_req_t              div_req;
    ktsamp_pkg::div_rsp_t              div_rsp;

    // helpers
    logic                              in_fire;
    logic                              wrap_rep;
    logic [ktsamp_pkg::KEY_CW-1:0]     n_keys;
    logic                              neg;
    logic [40:0]                       mag;
    logic [31:0]                       r_tmp;
    logic                              odd;
    logic                              hit;
    logic [31:0]                       gap;
    logic signed [48:0]                fprod;
    logic signed [32:0]                diff;
    logic signed [35:0]                sum;
    logic [31:0]                       rest_val;
    logic                              out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !ovalid_reg || !out_stall;
    assign wrap_rep  = wrap_mode_reg inside {ktsamp_pkg::WRAP_REPEAT, ktsamp_pkg::WRAP_PINGPONG};
    assign n_keys    = (key_count_reg > 7'(ktsamp_pkg::MAX_KEYS))
                     ? ktsamp_pkg::KEY_CW'(ktsamp_pkg::MAX_KEYS) : key_count_reg;
    assign neg       = frames_reg[40];
    assign mag       = neg ? 41'(-frames_reg) : frames_reg;
    assign hit       = (t_reg >= prev_reg) && (t_reg <= mem_rdata.frame_time);
    assign gap       = mem_rdata.frame_time - prev_reg;
    assign fprod     = sec_reg * $signed({1'b0, fps_reg});
    assign diff      = {b_reg[comp_reg][31], b_reg[comp_reg]}
                     - {a_reg[comp_reg][31], a_reg[comp_reg]};
    assign sum       = 36'(a_reg[comp_reg]) + 36'(prod_reg >>> FB);
    assign rest_val  = rest_kind_reg ? 32'(ktsamp_pkg::ONE_Q) : 32'd0;

    assign mem_we    = in_fire && (op == ktsamp_pkg::OP_WRITE);
    assign mem_wdata = '{frame_time: key_frame_time, x: key_x, y: key_y, z: key_z};

    // read address: slot scan, then the low and high keys of the pair
    always_comb
    begin
        case (state_reg)
            S_S0:    mem_raddr = ktsamp_pkg::KEY_AW'(1);
            S_SCMP:  mem_raddr = hit ? idx_reg[ktsamp_pkg::KEY_AW-1:0] - 1'b1
                                     : idx_reg[ktsamp_pkg::KEY_AW-1:0] + 1'b1;
            S_FDIV:  mem_raddr = idx_reg[ktsamp_pkg::KEY_AW-1:0] - 1'b1;
            S_RA:    mem_raddr = idx_reg[ktsamp_pkg::KEY_AW-1:0];
            default: mem_raddr = '0;
        endcase
    end

    // the divider serves the wrap (|frames| / duration) and the lerp factor
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = {7'd0, mag};
        div_req.divisor  = duration_reg;
        if (state_reg == S_WRAP && wrap_rep)
        begin
            div_req.start = 1'b1;
        end
        else if (state_reg == S_SCMP && hit)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = {(t_reg - prev_reg), FB'(0)};
            div_req.divisor  = (gap < ktsamp_pkg::MIN_GAP) ? ktsamp_pkg::MIN_GAP : gap;
        end
    end

    ktsamp_store u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (key_slot),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ktsamp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next   = state_reg;
        sec_next     = sec_reg;
        frames_next  = frames_reg;
        t_next       = t_reg;
        prev_next    = prev_reg;
        idx_next     = idx_reg;
        fac_next     = fac_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        res_next     = res_reg;
        prod_next    = prod_reg;
        comp_next    = comp_reg;
        found_next   = found_reg;
        active_next  = active_reg;
        ovalid_next  = ovalid_reg && out_stall;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        oz_next      = oz_reg;
        ofound_next  = ofound_reg;
        oactive_next = oactive_reg;
        r_tmp        = '0;
        odd          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && op == ktsamp_pkg::OP_SAMPLE)
                begin
                    sec_next    = sample_seconds;
                    found_next  = 1'b0;
                    res_next    = '{default: rest_val};
                    active_next = (duration_reg != 32'd0);
                    if (duration_reg == 32'd0)
                    begin
                        res_next   = '{default: 32'sd0};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                frames_next = fprod[48:8];   // arithmetic shift = floor
                state_next  = S_WRAP;
            end
            S_WRAP:
            begin
                if (wrap_rep)
                begin
                    state_next = S_WDIV;
                end
                else
                begin
                    // clamp to [0, duration]
                    if (neg)
                        r_tmp = 32'd0;
                    else if (frames_reg[39:0] > {8'd0, duration_reg})
                        r_tmp = duration_reg;
                    else
                        r_tmp = frames_reg[31:0];
                    t_next     = (r_tmp == 32'd0) ? 32'd1 : r_tmp;
                    state_next = S_SINIT;
                end
            end
            S_WDIV:
            begin
                if (div_rsp.done)
                begin
                    // floored modulo from magnitude division
                    if (neg && div_rsp.rem != 32'd0)
                    begin
                        r_tmp = duration_reg - div_rsp.rem;
                        odd   = !div_rsp.quot[0];
                    end
                    else
                    begin
                        r_tmp = div_rsp.rem;
                        odd   = div_rsp.quot[0];
                    end
                    if (wrap_mode_reg == ktsamp_pkg::WRAP_PINGPONG && odd)
                        r_tmp = duration_reg - r_tmp;
                    t_next     = (r_tmp == 32'd0) ? 32'd1 : r_tmp;
                    state_next = S_SINIT;
                end
            end
            S_SINIT:
            begin
                state_next = (n_keys < ktsamp_pkg::KEY_CW'(2)) ? S_DONE : S_S0;
            end
            S_S0:
            begin
                prev_next  = mem_rdata.frame_time;
                idx_next   = ktsamp_pkg::KEY_CW'(1);
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                if (hit)
                begin
                    state_next = S_FDIV;
                end
                else if (idx_reg + 1'b1 >= n_keys)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    prev_next = mem_rdata.frame_time;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            S_FDIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_RA;
                end
            end
            S_RA:
            begin
                a_next[0]  = mem_rdata.x;
                a_next[1]  = mem_rdata.y;
                a_next[2]  = mem_rdata.z;
                fac_next   = (div_rsp.quot > ktsamp_pkg::DIV_W'(ktsamp_pkg::ONE_Q))
                           ? ktsamp_pkg::ONE_Q : div_rsp.quot[FB:0];
                state_next = S_RB;
            end
            S_RB:
            begin
                b_next[0]  = mem_rdata.x;
                b_next[1]  = mem_rdata.y;
                b_next[2]  = mem_rdata.z;
                comp_next  = 2'd0;
                state_next = S_LMUL;
            end
            S_LMUL:
            begin
                prod_next  = diff * $signed({1'b0, fac_reg});
                state_next = S_LADD;
            end
            S_LADD:
            begin
                if (sum > 36'sd2147483647)
                    res_next[comp_reg] = 32'sh7FFFFFFF;
                else if (sum < -36'sd2147483648)
                    res_next[comp_reg] = 32'sh80000000;
                else
                    res_next[comp_reg] = sum[31:0];
                if (comp_reg == 2'd2)
                begin
                    found_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = S_LMUL;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next  = 1'b1;
                    ox_next      = res_reg[0];
                    oy_next      = res_reg[1];
                    oz_next      = res_reg[2];
                    ofound_next  = found_reg;
                    oactive_next = active_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sec_reg     <= sec_next;
        frames_reg  <= frames_next;
        t_reg       <= t_next;
        prev_reg    <= prev_next;
        idx_reg     <= idx_next;
        fac_reg     <= fac_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        res_reg     <= res_next;
        prod_reg    <= prod_next;
        comp_reg    <= comp_next;
        found_reg   <= found_next;
        active_reg  <= active_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        oz_reg      <= oz_next;
        ofound_reg  <= ofound_next;
        oactive_reg <= oactive_next;
    end

    assign out_valid    = ovalid_reg;
    assign out_x        = ox_reg;
    assign out_y        = oy_reg;
    assign out_z        = oz_reg;
    assign pair_found   = ofound_reg;
    assign track_active = oactive_reg;

endmodule

// ===== src/ktsamp_chk.sv =====
// Port-level checks for the keyframe track sampler, bound to the top level.
// No dependencies.
module ktsamp_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        op,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] out_x,
    input logic [31:0] out_y,
    input logic [31:0] out_z,
    input logic        pair_found,
    input logic        track_active
);

    // a keyframe write leaves the block ready
    a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !op |=> !in_stall)
        else $error("stall after keyframe write");

    // a sample occupies the block
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op |=> in_stall)
        else $error("no stall after sample word");

    // disabled track gives an all-zero result
    a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !track_active |->
            out_x == 32'd0 && out_y == 32'd0 && out_z == 32'd0 && !pair_found)
        else $error("inactive track with nonzero result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped under stall");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_x) && $stable(out_y) && $stable(out_z))
        else $error("stalled result changed");

endmodule

bind keyframe_track_sampler_top ktsamp_chk u_ktsamp_chk (.*);

// ===== tb/tb_keyframe_track_sampler_top.sv =====
// Self-checking testbench for keyframe_track_sampler_top: random keyframe tracks,
// APB register settings and sample words, checked against a behavioral predictor.
// Depends on ktsamp_pkg and the keyframe_track_sampler_top RTL.
module tb_keyframe_track_sampler_top;
    timeunit 1ns;
    timeprecision 1ps;

    // cycles with no accepted word, taken result or register write before the run is declared hung
    localparam int WATCHDOG_LIMIT = 6000;
    // receiver hold-off length used to back the block up into its input
    localparam int HOLD_CYCLES    = 500;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               found;
        logic               active;
    } sample_result_t;

    // Scoreboard: mirrors the keyframe memory and registers, predicts each sample
    // word and compares results in order.
    class sampler_scoreboard;
        logic [31:0] key_time_mem[ktsamp_pkg::MAX_KEYS];
        logic [31:0] key_x_mem[ktsamp_pkg::MAX_KEYS];
        logic [31:0] key_y_mem[ktsamp_pkg::MAX_KEYS];
        logic [31:0] key_z_mem[ktsamp_pkg::MAX_KEYS];
        logic [6:0]  key_count;
        logic [31:0] duration;
        logic [15:0] fps;
        logic [1:0]  wrap;
        logic        rest;
        sample_result_t expected_samples[$];
        int errors;

        function new();
            key_count = '0;
            duration  = '0;
            fps       = 16'd7680;
            wrap      = ktsamp_pkg::WRAP_REPEAT;
            rest      = 1'b0;
            errors    = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                ktsamp_pkg::REG_KEY_COUNT: key_count = v[6:0];
                ktsamp_pkg::REG_DURATION:  duration  = v;
                ktsamp_pkg::REG_FPS:       fps       = v[15:0];
                ktsamp_pkg::REG_WRAP:      wrap      = v[1:0];
                ktsamp_pkg::REG_REST:      rest      = v[0];
                default: ;
            endcase
        endfunction

        function logic [31:0] lerp_q(logic [31:0] a, logic [31:0] b, longint f);
            longint sa, sb, v;
            sa = longint'(signed'(a));
            sb = longint'(signed'(b));
            v = sa + (((sb - sa) * f) >>> ktsamp_pkg::FRAC_BITS);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            return v[31:0];
        endfunction

        function sample_result_t sample_track(logic signed [31:0] sec);
            sample_result_t e;
            longint frames, d, qq, r, gap, f, min_gap, one_q;
            logic [31:0] t, dt, rv;
            int n;
            e = '0;
            if (duration == 32'd0) return e;
            e.active = 1'b1;
            min_gap = longint'({32'd0, ktsamp_pkg::MIN_GAP});
            one_q   = longint'(ktsamp_pkg::ONE_Q);
            frames = (longint'(sec) * longint'({48'd0, fps})) >>> 8;
            d = longint'({32'd0, duration});
            if (wrap == ktsamp_pkg::WRAP_REPEAT || wrap == ktsamp_pkg::WRAP_PINGPONG) begin
                qq = frames / d;
                r  = frames % d;
                if (r < 0) begin
                    r  = r + d;
                    qq = qq - 1;
                end
                // odd periods run backward in ping-pong
                if (wrap == ktsamp_pkg::WRAP_PINGPONG && qq[0]) r = d - r;
                t = r[31:0];
            end else begin
                // clamp, and the undefined mode 3 behaves the same
                if (frames < 0) t = 32'd0;
                else if (frames > d) t = duration;
                else t = frames[31:0];
            end
            if (t < 32'd1) t = 32'd1;
            rv = rest ? 32'(ktsamp_pkg::ONE_Q) : 32'd0;
            e.x = rv;
            e.y = rv;
            e.z = rv;
            n = (key_count > ktsamp_pkg::MAX_KEYS) ? ktsamp_pkg::MAX_KEYS : int'(key_count);
            for (int i = 0; i + 1 < n; i++) begin
                if (t >= key_time_mem[i] && t <= key_time_mem[i+1]) begin
                    dt  = key_time_mem[i+1] - key_time_mem[i];
                    gap = longint'({32'd0, dt});
                    if (gap < min_gap) gap = min_gap;
                    dt = t - key_time_mem[i];
                    f  = (longint'({32'd0, dt}) << ktsamp_pkg::FRAC_BITS) / gap;
                    if (f > one_q) f = one_q;
                    e.x = lerp_q(key_x_mem[i], key_x_mem[i+1], f);
                    e.y = lerp_q(key_y_mem[i], key_y_mem[i+1], f);
                    e.z = lerp_q(key_z_mem[i], key_z_mem[i+1], f);
                    e.found = 1'b1;
                    break;
                end
            end
            return e;
        endfunction

        function void note_word(logic o, logic [5:0] slot, logic [31:0] kt,
                                logic [31:0] kx, logic [31:0] ky, logic [31:0] kz,
                                logic signed [31:0] sec);
            if (o == ktsamp_pkg::OP_WRITE) begin
                key_time_mem[slot] = kt;
                key_x_mem[slot]    = kx;
                key_y_mem[slot]    = ky;
                key_z_mem[slot]    = kz;
            end else begin
                expected_samples.push_back(sample_track(sec));
            end
        endfunction

        function void check_result(sample_result_t got);
            sample_result_t e;
            if (expected_samples.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word: %h", got);
                return;
            end
            e = expected_samples.pop_front();
            if (got !== e) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp x=%h y=%h z=%h pf=%b ta=%b ",
                              "got x=%h y=%h z=%h pf=%b ta=%b"},
                             e.x, e.y, e.z, e.found, e.active,
                             got.x, got.y, got.z, got.found, got.active);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel, penable, pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata, prdata;
    logic               pready;
    logic               in_valid, in_stall;
    logic               op;
    logic [5:0]         key_slot;
    logic [31:0]        key_frame_time;
    logic signed [31:0] key_x, key_y, key_z, sample_seconds;
    logic               out_valid, out_stall;
    logic signed [31:0] out_x, out_y, out_z;
    logic               pair_found, track_active;

    keyframe_track_sampler_top dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .op(op), .key_slot(key_slot),
        .key_frame_time(key_frame_time), .key_x(key_x), .key_y(key_y), .key_z(key_z),
        .sample_seconds(sample_seconds),
        .out_valid(out_valid), .out_stall(out_stall), .out_x(out_x), .out_y(out_y),
        .out_z(out_z), .pair_found(pair_found), .track_active(track_active)
    );

    sampler_scoreboard sb = new();

    // receiver control, set by the stimulus process
    bit rx_calm;      // no random stalls in this phase
    bit hold_req;     // request one long hold-off
    int idle_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, plus a long hold-off counted here when requested.
    initial begin
        int hold_left, gap_left;
        bit s;
        out_stall = 1'b0;
        hold_left = 0;
        gap_left  = 0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                s = 1'b1;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                s = 1'b1;
            end else begin
                if (gap_left == 0 && !rx_calm && $urandom_range(0, 3) == 0)
                    gap_left = gap_len();
                s = (gap_left > 0);
                if (gap_left > 0) gap_left--;
            end
            out_stall <= s;
        end
    end

    // Monitor and watchdog: sample both channels at the edge, before the drivers update.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                sb.note_word(op, key_slot, key_frame_time, key_x, key_y, key_z,
                             sample_seconds);
            if (out_valid && !out_stall)
                sb.check_result({out_x, out_y, out_z, pair_found, track_active});
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Setup phase, access phase, then an idle phase so the next write starts cleanly.
    task automatic apb_write(logic [2:0] idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, v);
        @(posedge clk);
    endtask

    // Offer one word and hold it until taken; then maybe drop valid for a gap.
    task automatic send_word(logic o, logic [5:0] slot, logic [31:0] kt, logic [31:0] kx,
                             logic [31:0] ky, logic [31:0] kz, logic [31:0] sec);
        int g;
        in_valid       <= 1'b1;
        op             <= o;
        key_slot       <= slot;
        key_frame_time <= kt;
        key_x          <= kx;
        key_y          <= ky;
        key_z          <= kz;
        sample_seconds <= sec;
        do @(posedge clk); while (in_stall);
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Sender pause: every expected result in, then idle so a trailing write can finish.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_samples.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [31:0] key_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    // Seconds mostly within a few track lengths, some extremes and full-range noise.
    function automatic logic [31:0] pick_seconds(logic [31:0] dur, logic [15:0] rate);
        longint span;
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: case ($urandom_range(0, 4))
                   0: return 32'd0;
                   1: return 32'h7FFF_FFFF;
                   2: return 32'h8000_0000;
                   3: return 32'd1;
                   default: return 32'hFFFF_FFFF;
               endcase
            default: ;
        endcase
        if (rate == 16'd0) return $urandom();
        span = (longint'({32'd0, dur}) * 3 * 256) / longint'({48'd0, rate});
        if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
        v = $urandom_range(0, 32'(span));
        if ($urandom_range(0, 9) == 0) v = -v;
        return v;
    endfunction

    // Write a track into slots lo..hi-1: mostly sorted, with tiny and repeated gaps.
    task automatic write_track(int lo, int hi, logic [31:0] dur);
        longint cur, base;
        logic [31:0] kt;
        cur  = $urandom_range(0, 3);
        base = longint'({32'd0, dur}) / ((hi > lo) ? (hi - lo) : 1);
        if (base < 1) base = 1;
        if (base > 64'h7FFF_FFFF) base = 64'h7FFF_FFFF;
        for (int i = lo; i < hi; i++) begin
            case ($urandom_range(0, 19))
                0, 1: cur = cur + $urandom_range(0, 3);
                2:    cur = $urandom();
                default: cur = cur + $urandom_range(1, 32'(base * 2));
            endcase
            kt = cur[31:0];
            send_word(ktsamp_pkg::OP_WRITE, 6'(i), kt, key_value(), key_value(), key_value(),
                      $urandom());
        end
    endtask

    task automatic run_phase(logic [6:0] kc, logic [31:0] dur, logic [15:0] rate,
                             logic [1:0] wm, logic rk, int nsamp, bit hold);
        int n;
        logic [31:0] r;
        drain();
        apb_write(ktsamp_pkg::REG_KEY_COUNT, {25'd0, kc});
        apb_write(ktsamp_pkg::REG_DURATION, dur);
        apb_write(ktsamp_pkg::REG_FPS, {16'd0, rate});
        apb_write(ktsamp_pkg::REG_WRAP, {30'd0, wm});
        apb_write(ktsamp_pkg::REG_REST, {31'd0, rk});
        n = (kc > ktsamp_pkg::MAX_KEYS) ? ktsamp_pkg::MAX_KEYS : int'(kc);
        write_track(0, (n < 2) ? 2 : n, dur);
        if (hold) hold_req = 1'b1;
        for (int i = 0; i < nsamp; i++) begin
            if ($urandom_range(0, 14) == 0) begin
                // stray write with random content into any slot
                r = $urandom();
                send_word(ktsamp_pkg::OP_WRITE, 6'($urandom()), $urandom(), r, $urandom(),
                          $urandom(), $urandom());
            end else begin
                send_word(ktsamp_pkg::OP_SAMPLE, 6'($urandom()), $urandom(), $urandom(),
                          $urandom(), $urandom(), pick_seconds(dur, rate));
            end
        end
    endtask

    initial begin
        logic [31:0] dur;
        logic [6:0]  kc;
        logic [15:0] rate;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        op             = ktsamp_pkg::OP_WRITE;
        key_slot       = '0;
        key_frame_time = '0;
        key_x          = '0;
        key_y          = '0;
        key_z          = '0;
        sample_seconds = '0;
        rx_calm        = 1'b0;
        hold_req       = 1'b0;
        idle_cycles    = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every slot written once so no sample ever reads an unwritten key
        write_track(0, ktsamp_pkg::MAX_KEYS, 32'h0100_0000);

        // directed settings: plain repeat, disabled track, too few keys with rest one,
        // oversized key count with clamp and full-scale rate under a long hold-off,
        // undefined wrap with zero rate, ping-pong at the smallest and largest duration
        rx_calm = 1'b1;
        run_phase(7'd4, 32'd100 << 16, 16'd7680, ktsamp_pkg::WRAP_REPEAT, 1'b0, 8, 1'b0);
        rx_calm = 1'b0;
        run_phase(7'd8, 32'd0, 16'd7680, ktsamp_pkg::WRAP_REPEAT, 1'b0, 3, 1'b0);
        run_phase(7'd1, 32'd50 << 16, 16'd7680, ktsamp_pkg::WRAP_CLAMP, 1'b1, 3, 1'b0);
        run_phase(7'd127, 32'd200 << 16, 16'hFFFF, ktsamp_pkg::WRAP_CLAMP, 1'b0, 20, 1'b1);
        run_phase(7'd6, 32'd40 << 16, 16'd0, 2'd3, 1'b1, 3, 1'b0);
        run_phase(7'd5, 32'd1, 16'd7680, ktsamp_pkg::WRAP_PINGPONG, 1'b0, 3, 1'b0);
        run_phase(7'd64, 32'hFFFF_FFFF, 16'd256, ktsamp_pkg::WRAP_PINGPONG, 1'b1, 4, 1'b0);

        // random settings; mostly small key counts keep samples short
        for (int p = 0; p < 8; p++) begin
            rx_calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 5))
                0:       kc = $urandom_range(0, 127);
                1:       kc = 7'd64;
                default: kc = $urandom_range(2, 12);
            endcase
            case ($urandom_range(0, 5))
                0:       dur = $urandom();
                1:       dur = $urandom_range(1, 16);
                default: dur = $urandom_range(1, 1000) << 16;
            endcase
            case ($urandom_range(0, 5))
                0:       rate = $urandom();
                1:       rate = 16'hFFFF;
                default: rate = $urandom_range(256, 16000);
            endcase
            run_phase(kc, dur, rate, 2'($urandom()), 1'($urandom()), 16, (p == 5));
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_samples.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.expected_samples.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
